@@ rtl/core/gregorian_date_decrement_assert.svh @@
// Assertion macros shared by the date decrement RTL.
`ifndef GREGORIAN_DATE_DECREMENT_ASSERT_SVH
`define GREGORIAN_DATE_DECREMENT_ASSERT_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define GDD_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define GDD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/gdd_pkg.sv @@
// Shared constants, types and the month length table of the date decrement block.
package gdd_pkg;

	localparam int COUNT_WIDTH_DEF = 12;
	localparam int YEAR_WIDTH_DEF  = 16;

	localparam int RES_MOD   = 25;
	localparam int WEEK_DAYS = 7;

	localparam logic [4:0] DAY_FEB      = 5'd28;
	localparam logic [4:0] DAY_FEB_LEAP = 5'd29;
	localparam logic [4:0] DAY_MAX      = 5'd31;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [2:0] MODE_DAYS      = 3'd0;
	localparam logic [2:0] MODE_WEEKS     = 3'd1;
	localparam logic [2:0] MODE_MONTHS    = 3'd2;
	localparam logic [2:0] MODE_YEARS     = 3'd3;
	localparam logic [2:0] MODE_YEARS_DIR = 3'd4;

	typedef enum logic [1:0] {
		STEP_HOLD  = 2'd0,
		STEP_MONTH = 2'd1,
		STEP_YEAR  = 2'd2
	} step_kind_t;

	typedef struct packed {
		logic busy;
		logic done;
	} res_stat_t;

	// Length of a month in a common year.
	function automatic logic [4:0] month_base_len(input logic [3:0] m);
		logic [4:0] len;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			MONTH_FEB:                len = DAY_FEB;
			default:                  len = DAY_MAX;
		endcase
		return len;
	endfunction

endpackage

@@ rtl/core/gdd_res25.sv @@
// Unit that finds a signed year modulo 25 by reciprocal multiplication.
module gdd_res25 #(
	parameter int YEAR_WIDTH = gdd_pkg::YEAR_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [YEAR_WIDTH-1:0] operand,
	output gdd_pkg::res_stat_t    stat,
	output logic [4:0]            residue
);

	localparam int          RSH     = 35;
	localparam int          QW      = 64 - RSH;
	localparam logic [31:0] RECIP   = 32'h51EB_851F;
	localparam logic [63:0] WRAP    = 64'd1 << YEAR_WIDTH;
	localparam logic [4:0]  NEG_ADJ = 5'(WRAP % 64'(gdd_pkg::RES_MOD));

	logic [31:0]   op_q;
	logic [QW-1:0] quo_q;
	logic [4:0]    acc_q;
	logic          neg_q;
	logic          mul_q;
	logic          sub_q;
	logic          fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q <= 1'b0;
			sub_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			mul_q <= start;
			sub_q <= mul_q;
			fin_q <= sub_q;
		end
	end

	// The reciprocal of 25 scaled by 2^35 gives the exact quotient of any 32-bit operand.
	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= 32'(operand);
			neg_q <= operand[YEAR_WIDTH-1];
		end
		if (mul_q) begin
			quo_q <= QW'((64'(op_q) * 64'(RECIP)) >> RSH);
		end
		if (sub_q) begin
			acc_q <= 5'(op_q - ((32'(quo_q) << 4) + (32'(quo_q) << 3) + 32'(quo_q)));
		end
	end

	// A negative year was reduced as its unsigned pattern, so take 2^W back off.
	always_comb begin
		residue = acc_q;
		if (neg_q) begin
			if (acc_q >= NEG_ADJ) begin
				residue = acc_q - NEG_ADJ;
			end else begin
				residue = acc_q + (5'(gdd_pkg::RES_MOD) - NEG_ADJ);
			end
		end
	end

	assign stat.busy = mul_q | sub_q | fin_q;
	assign stat.done = fin_q;

endmodule

@@ rtl/core/gdd_step.sv @@
// Shared step unit: moves back one month or one year, or holds the date, and gives the new month length.
module gdd_step #(
	parameter int YEAR_WIDTH = gdd_pkg::YEAR_WIDTH_DEF
) (
	input  gdd_pkg::step_kind_t   kind,
	input  logic [3:0]            m,
	input  logic [YEAR_WIDTH-1:0] y,
	input  logic [4:0]            r,
	output logic [3:0]            nm,
	output logic [YEAR_WIDTH-1:0] ny,
	output logic [4:0]            nr,
	output logic [4:0]            nlen
);

	localparam logic [63:0]           YMAX64 = (64'd1 << (YEAR_WIDTH - 1)) - 64'd1;
	localparam logic [4:0]            RMAX   = 5'(YMAX64 % 64'(gdd_pkg::RES_MOD));
	localparam logic [YEAR_WIDTH-1:0] YMIN   = {1'b1, {(YEAR_WIDTH-1){1'b0}}};

	logic dec_year;
	logic leap;

	always_comb begin
		nm       = m;
		dec_year = 1'b0;
		case (kind)
			gdd_pkg::STEP_MONTH: begin
				if (m == gdd_pkg::MONTH_JAN) begin
					nm       = gdd_pkg::MONTH_DEC;
					dec_year = 1'b1;
				end else begin
					nm = m - 4'd1;
				end
			end
			gdd_pkg::STEP_YEAR: dec_year = 1'b1;
			default:            dec_year = 1'b0;
		endcase
	end

	// The residue follows the year down, and jumps when the year wraps.
	always_comb begin
		ny = y;
		nr = r;
		if (dec_year) begin
			ny = y - YEAR_WIDTH'(1);
			if (y == YMIN) begin
				nr = RMAX;
			end else if (r == 5'd0) begin
				nr = 5'(gdd_pkg::RES_MOD - 1);
			end else begin
				nr = r - 5'd1;
			end
		end
	end

	assign leap = (ny[1:0] == 2'b00) && ((nr != 5'd0) || (ny[3:0] == 4'b0000));

	always_comb begin
		if (nm == gdd_pkg::MONTH_FEB) begin
			nlen = leap ? gdd_pkg::DAY_FEB_LEAP : gdd_pkg::DAY_FEB;
		end else begin
			nlen = gdd_pkg::month_base_len(nm);
		end
	end

endmodule

@@ rtl/core/gregorian_date_decrement.sv @@
// Top level of the Gregorian date decrement block: sequencer and date registers.
// An item is taken when start is high and busy is low; done then marks the result word on
// day_out, month_out and year_out for exactly one cycle, and it must be taken then since the
// block cannot hold it. After acceptance the year is reduced modulo 25 by a reciprocal
// multiplication in the residue unit, after which the shared step unit does one step a
// cycle: one per month boundary crossed in day and week mode, plus one when days are left over
// within the last month, and one per unit of count in month and stepwise year mode, before
// it finishes; direct year mode only clamps 29 February, and the unused modes do no step.
// busy is high from acceptance until done rises.
`include "gregorian_date_decrement_assert.svh"

module gregorian_date_decrement #(
	parameter int COUNT_WIDTH = gdd_pkg::COUNT_WIDTH_DEF,
	parameter int YEAR_WIDTH  = gdd_pkg::YEAR_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   mode,
	input  logic [COUNT_WIDTH-1:0]       count,
	input  logic [4:0]                   day_in,
	input  logic [3:0]                   month_in,
	input  logic signed [YEAR_WIDTH-1:0] year_in,
	output logic                         done,
	output logic [4:0]                   day_out,
	output logic [3:0]                   month_out,
	output logic signed [YEAR_WIDTH-1:0] year_out
);

	localparam int RW = (COUNT_WIDTH + 3 < 6) ? 6 : COUNT_WIDTH + 3;
	localparam int SW = (YEAR_WIDTH > COUNT_WIDTH) ? YEAR_WIDTH : COUNT_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RES  = 3'b010,
		ST_RUN  = 3'b100
	} state_t;

	state_t                state_q;
	logic                  done_q;
	logic [2:0]            mode_q;
	logic [RW-1:0]         rem_q;
	logic [4:0]            d_q;
	logic [3:0]            m_q;
	logic [YEAR_WIDTH-1:0] y_q;
	logic [4:0]            r_q;

	logic                  accept;
	logic [YEAR_WIDTH-1:0] y_load;
	logic [SW-1:0]         y_diff;
	logic [RW-1:0]         rem_load;
	logic [4:0]            d_load;
	logic [3:0]            m_load;

	gdd_pkg::res_stat_t    res_stat;
	logic [4:0]            res_val;
	gdd_pkg::step_kind_t   kind;
	logic [3:0]            st_m;
	logic [YEAR_WIDTH-1:0] st_y;
	logic [4:0]            st_r;
	logic [4:0]            st_len;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		y_diff = SW'(year_in) - SW'(count);
		if (mode == gdd_pkg::MODE_YEARS_DIR) begin
			y_load = y_diff[YEAR_WIDTH-1:0];
		end else begin
			y_load = year_in;
		end
		if (mode == gdd_pkg::MODE_WEEKS) begin
			rem_load = (RW'(count) << 3) - RW'(count);
		end else begin
			rem_load = RW'(count);
		end
		d_load = (day_in == 5'd0) ? 5'd1 : day_in;
		if (month_in == 4'd0) begin
			m_load = gdd_pkg::MONTH_JAN;
		end else if (month_in > gdd_pkg::MONTH_DEC) begin
			m_load = gdd_pkg::MONTH_DEC;
		end else begin
			m_load = month_in;
		end
	end

	always_comb begin
		case (mode_q) inside
			gdd_pkg::MODE_DAYS, gdd_pkg::MODE_WEEKS, gdd_pkg::MODE_MONTHS:
				kind = gdd_pkg::STEP_MONTH;
			gdd_pkg::MODE_YEARS:
				kind = gdd_pkg::STEP_YEAR;
			default:
				kind = gdd_pkg::STEP_HOLD;
		endcase
	end

	gdd_res25 #(
		.YEAR_WIDTH(YEAR_WIDTH)
	) u_res25 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.operand(y_load),
		.stat   (res_stat),
		.residue(res_val)
	);

	gdd_step #(
		.YEAR_WIDTH(YEAR_WIDTH)
	) u_step (
		.kind(kind),
		.m   (m_q),
		.y   (y_q),
		.r   (r_q),
		.nm  (st_m),
		.ny  (st_y),
		.nr  (st_r),
		.nlen(st_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (res_stat.done) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (kind == gdd_pkg::STEP_HOLD || rem_q == '0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			rem_q  <= rem_load;
			d_q    <= d_load;
			m_q    <= m_load;
			y_q    <= y_load;
		end else if (state_q == ST_RES) begin
			r_q <= res_val;
		end else if (state_q == ST_RUN) begin
			case (mode_q) inside
				gdd_pkg::MODE_DAYS, gdd_pkg::MODE_WEEKS: begin
					if (rem_q != '0) begin
						if (RW'(d_q) > rem_q) begin
							d_q   <= d_q - 5'(rem_q);
							rem_q <= '0;
						end else begin
							rem_q <= rem_q - RW'(d_q);
							m_q   <= st_m;
							y_q   <= st_y;
							r_q   <= st_r;
							d_q   <= st_len;
						end
					end
				end
				gdd_pkg::MODE_MONTHS: begin
					if (rem_q != '0) begin
						rem_q <= rem_q - RW'(1);
						m_q   <= st_m;
						y_q   <= st_y;
						r_q   <= st_r;
						if (d_q > st_len) begin
							d_q <= st_len;
						end
					end
				end
				gdd_pkg::MODE_YEARS, gdd_pkg::MODE_YEARS_DIR: begin
					if (kind == gdd_pkg::STEP_HOLD || rem_q != '0) begin
						if (kind != gdd_pkg::STEP_HOLD) begin
							rem_q <= rem_q - RW'(1);
						end
						y_q <= st_y;
						r_q <= st_r;
						if (m_q == gdd_pkg::MONTH_FEB && d_q == gdd_pkg::DAY_FEB_LEAP &&
						    st_len == gdd_pkg::DAY_FEB) begin
							d_q <= gdd_pkg::DAY_FEB;
						end
					end
				end
				default: d_q <= d_q;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign day_out   = d_q;
	assign month_out = m_q;
	assign year_out  = y_q;

	`GDD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after a start")
	`GDD_ASSERT_IMP(a_done_idle, done, !busy, "result word given while still busy")
	`GDD_ASSERT_IMP(a_month_range, done,
		month_out >= gdd_pkg::MONTH_JAN && month_out <= gdd_pkg::MONTH_DEC,
		"result month out of range")
	`GDD_ASSERT_IMP(a_day_nonzero, done, day_out != 5'd0, "result day is zero")
	`GDD_ASSERT_IMP(a_res_in_state, res_stat.busy, state_q == ST_RES,
		"residue unit running outside its phase")

endmodule
